FILE: hdl/mns_pkg.sv
// ----------------------------------------------------------------------------
// mns_pkg
// Shared types and constants of the melody note sequencer.
// ----------------------------------------------------------------------------
package mns_pkg;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_KEY  = 2'd1,
		FUNC_PLAY = 2'd2,
		FUNC_LOAD = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_SELECT = 2'd0,
		MODE_PLAY   = 2'd1,
		MODE_PAUSE  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_OK   = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	localparam logic [3:0] KEY_TRANSPORT  = 4'd15;
	localparam logic [3:0] SONG_COUNT_RST = 4'd9;

	// tone is cut at len*17/20; done as len * 17 * ceil(2^16/20) >> 16
	localparam int unsigned CUT_NUM   = 17;
	localparam int unsigned CUT_DEN   = 20;
	localparam int unsigned CUT_SHIFT = 16;
	localparam logic [15:0] CUT_MUL   =
		16'(CUT_NUM * (((1 << CUT_SHIFT) + CUT_DEN - 1) / CUT_DEN));

	typedef struct packed {
		func_t       func;
		logic [3:0]  key_code;
		logic [7:0]  song_number;
		logic [3:0]  load_song;
		logic [4:0]  load_index;
		logic [15:0] load_tone_hz;
		logic [7:0]  load_ticks;
		logic        load_last;
	} item_t;

	typedef struct packed {
		logic [15:0] tone_hz;
		mode_t       mode;
		logic [3:0]  song_sel;
		logic [4:0]  note_pos;
		logic        song_done;
		status_t     cmd_status;
	} result_t;

	typedef struct packed {
		logic [7:0] cut;
		logic [7:0] len;
		logic       last;
	} ctl_t;

	function automatic logic [7:0] cut_of(input logic [7:0] len);
		logic [23:0] p;
		p = {16'd0, len} * {8'd0, CUT_MUL};
		return p[23:16];
	endfunction

endpackage

FILE: hdl/mns_ram.sv
// ----------------------------------------------------------------------------
// mns_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mns_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/mns_core.sv
// ----------------------------------------------------------------------------
// mns_core
// Player state, note stores and the read-modify-update step of one transaction.
// ----------------------------------------------------------------------------
module mns_core #(
	parameter int SONG_SLOTS     = 16,
	parameter int NOTES_PER_SONG = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        song_count,
	input  logic              issue,
	input  mns_pkg::item_t    item,
	output logic              busy,
	output logic              res_valid,
	output mns_pkg::result_t  res
);
	import mns_pkg::*;

	localparam int SW    = $clog2(SONG_SLOTS);
	localparam int IW    = $clog2(NOTES_PER_SONG);
	localparam int DEPTH = SONG_SLOTS * NOTES_PER_SONG;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [IW-1:0] IDX_LAST = IW'(NOTES_PER_SONG - 1);
	localparam logic [7:0]    SLOT_LIM = 8'(SONG_SLOTS);
	localparam logic [8:0]    NOTE_LIM = 9'(NOTES_PER_SONG);

	function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] s, input logic [AW-1:0] i);
		return s * AW'(NOTES_PER_SONG) + i;
	endfunction

	mode_t          mode_q;
	logic [SW-1:0]  song_q;
	logic [IW-1:0]  idx_q;
	logic [7:0]     tick_q;
	logic [15:0]    hz_q;

	logic           s1_valid_q;
	func_t          func_s1;
	logic           key_ok_s1;
	logic           key_ss_s1;
	logic           num_ok_s1;
	logic [SW-1:0]  key_song_s1;
	logic [SW-1:0]  num_song_s1;

	logic           key_ok;
	logic           key_ss;
	logic           num_ok;
	logic [SW-1:0]  key_song;
	logic [SW-1:0]  num_song;
	logic [IW-1:0]  idx_next;
	logic           wr_ok;
	logic [AW-1:0]  waddr;
	logic [AW-1:0]  ctl_raddr;
	logic [AW-1:0]  tone_raddr;
	ctl_t           ctl_wdata;
	ctl_t           ctl_rd;
	logic [15:0]    tone_rd;

	mode_t          n_mode;
	logic [SW-1:0]  n_song;
	logic [IW-1:0]  n_idx;
	logic [7:0]     n_tick;
	logic [15:0]    n_hz;
	logic           n_done;
	status_t        n_status;
	logic [7:0]     t1;

	// decode and store access at issue
	always_comb begin
		key_ok   = (item.key_code != 4'd0) && (item.key_code <= song_count) &&
			({4'd0, item.key_code} <= SLOT_LIM);
		key_ss   = item.key_code == KEY_TRANSPORT;
		num_ok   = (item.song_number != 8'd0) && (item.song_number <= {4'd0, song_count}) &&
			(item.song_number <= SLOT_LIM);
		key_song = SW'(item.key_code - 4'd1);
		num_song = SW'(item.song_number - 8'd1);
		idx_next = (idx_q == IDX_LAST) ? '0 : idx_q + IW'(1);

		wr_ok = issue && (item.func == FUNC_LOAD) && ({4'd0, item.load_song} < SLOT_LIM) &&
			({4'd0, item.load_index} < NOTE_LIM);
		waddr = addr_of(AW'(item.load_song), AW'(item.load_index));
		ctl_wdata.cut  = cut_of(item.load_ticks);
		ctl_wdata.len  = item.load_ticks;
		ctl_wdata.last = item.load_last;

		ctl_raddr = addr_of(AW'(song_q), AW'(idx_q));
		case (item.func)
			FUNC_TICK: tone_raddr = addr_of(AW'(song_q), AW'(idx_next));
			FUNC_KEY: begin
				tone_raddr = addr_of(AW'(song_q),
					(mode_q == MODE_SELECT) ? '0 : AW'(idx_q));
			end
			FUNC_PLAY: tone_raddr = addr_of(AW'(num_song), '0);
			default: tone_raddr = ctl_raddr;
		endcase
	end

	mns_ram #(
		.WIDTH($bits(ctl_t)),
		.DEPTH(DEPTH)
	) u_ctl_ram (
		.clk  (clk),
		.we   (wr_ok),
		.waddr(waddr),
		.wdata(ctl_wdata),
		.raddr(ctl_raddr),
		.rdata(ctl_rd)
	);

	mns_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_tone_ram (
		.clk  (clk),
		.we   (wr_ok),
		.waddr(waddr),
		.wdata(item.load_tone_hz),
		.raddr(tone_raddr),
		.rdata(tone_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			func_s1     <= item.func;
			key_ok_s1   <= key_ok;
			key_ss_s1   <= key_ss;
			num_ok_s1   <= num_ok;
			key_song_s1 <= key_song;
			num_song_s1 <= num_song;
		end
	end

	// state update with the store data
	always_comb begin
		n_mode   = mode_q;
		n_song   = song_q;
		n_idx    = idx_q;
		n_tick   = tick_q;
		n_hz     = hz_q;
		n_done   = 1'b0;
		n_status = ST_NONE;
		t1       = tick_q + 8'd1;
		case (func_s1)
			FUNC_TICK: begin
				if (mode_q == MODE_PLAY) begin
					if (t1 >= ctl_rd.len) begin
						n_tick = 8'd0;
						if (ctl_rd.last || (idx_q == IDX_LAST)) begin
							n_idx  = '0;
							n_mode = MODE_SELECT;
							n_hz   = 16'd0;
							n_done = 1'b1;
						end else begin
							n_idx = idx_next;
							n_hz  = tone_rd;
						end
					end else begin
						n_tick = t1;
						if (t1 == ctl_rd.cut) begin
							n_hz = 16'd0;
						end
					end
				end
			end
			FUNC_KEY: begin
				if (key_ok_s1) begin
					n_song = key_song_s1;
					n_mode = MODE_SELECT;
					n_hz   = 16'd0;
				end else if (key_ss_s1) begin
					if (mode_q == MODE_PLAY) begin
						n_mode = MODE_PAUSE;
						n_hz   = 16'd0;
					end else begin
						if (mode_q == MODE_SELECT) begin
							n_idx = '0;
						end
						n_tick = 8'd0;
						n_mode = MODE_PLAY;
						n_hz   = tone_rd;
					end
				end
			end
			FUNC_PLAY: begin
				if (num_ok_s1) begin
					n_song   = num_song_s1;
					n_mode   = MODE_PLAY;
					n_idx    = '0;
					n_tick   = 8'd0;
					n_hz     = tone_rd;
					n_status = ST_OK;
				end else begin
					n_status = ST_BAD;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SELECT;
			song_q <= '0;
			idx_q  <= '0;
			tick_q <= 8'd0;
			hz_q   <= 16'd0;
		end else if (s1_valid_q) begin
			mode_q <= n_mode;
			song_q <= n_song;
			idx_q  <= n_idx;
			tick_q <= n_tick;
			hz_q   <= n_hz;
		end
	end

	assign busy      = s1_valid_q;
	assign res_valid = s1_valid_q;

	always_comb begin
		res.tone_hz    = n_hz;
		res.mode       = n_mode;
		res.song_sel   = 4'(n_song);
		res.note_pos   = 5'(n_idx);
		res.song_done  = n_done;
		res.cmd_status = n_status;
	end

	a_issue_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> !s1_valid_q)
		else $error("issue while a transaction is in the update stage");

	a_done_to_select: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && res.song_done |->
			res.mode == MODE_SELECT && res.tone_hz == 16'd0 && res.note_pos == 5'd0)
		else $error("song end did not return to selecting");

	a_silent_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_PLAY |-> hz_q == 16'd0)
		else $error("tone sounding while not playing");

endmodule

FILE: hdl/melody_note_sequencer_top.sv
// ----------------------------------------------------------------------------
// melody_note_sequencer_top
// Note-store melody player with event input, result output and config write.
// ----------------------------------------------------------------------------
// Event channel (evt_valid/evt_stall): func selects tick, key press, remote
// play or note-store write; the other fields qualify it. Every transaction
// gives exactly one result transaction on res_valid/res_stall with the tone,
// mode, selected song, note position, song-end flag and command status.
// An event is held in an input register and then issued: the issue cycle
// reads the note control and tone stores, the next updates the player
// state and loads the result register. No new event is issued while the
// previous one is in its update step. A stalled result holds in its
// register; one further event waits in the input register, then evt_stall
// rises.
// Config channel (cfg_valid/cfg_ready) writes song_count; cfg_ready is
// always high. Write it only with no event pending.
// Reset clears player state to selecting, song 0, note 0, silent, and
// song_count to 9. The note stores are not cleared and keep their contents.
// ----------------------------------------------------------------------------
module melody_note_sequencer_top #(
	parameter int SONG_SLOTS     = 16,
	parameter int NOTES_PER_SONG = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        evt_valid,
	output logic        evt_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  key_code,
	input  logic [7:0]  song_number,
	input  logic [3:0]  load_song,
	input  logic [4:0]  load_index,
	input  logic [15:0] load_tone_hz,
	input  logic [7:0]  load_ticks,
	input  logic        load_last,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [15:0] tone_hz,
	output logic [1:0]  mode,
	output logic [3:0]  song_sel,
	output logic [4:0]  note_pos,
	output logic        song_done,
	output logic [1:0]  cmd_status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	import mns_pkg::*;

	logic       song_count_q;
	logic [3:0] song_count_r_q;
	logic       buf_valid_q;
	item_t      buf_item_q;
	logic       out_valid_q;
	result_t    res_q;
	logic       issue;
	logic       busy;
	logic       core_valid;
	result_t    core_res;
	logic       evt_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			song_count_q   <= 1'b0;
			song_count_r_q <= SONG_COUNT_RST;
		end else if (cfg_valid) begin
			song_count_q   <= 1'b1;
			song_count_r_q <= cfg_data;
		end
	end

	assign issue     = buf_valid_q && !busy && (!out_valid_q || !res_stall);
	assign evt_stall = buf_valid_q && !issue;
	assign evt_take  = evt_valid && !evt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
		end else if (evt_take) begin
			buf_valid_q <= 1'b1;
		end else if (issue) begin
			buf_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			buf_item_q.func         <= func_t'(func);
			buf_item_q.key_code     <= key_code;
			buf_item_q.song_number  <= song_number;
			buf_item_q.load_song    <= load_song;
			buf_item_q.load_index   <= load_index;
			buf_item_q.load_tone_hz <= load_tone_hz;
			buf_item_q.load_ticks   <= load_ticks;
			buf_item_q.load_last    <= load_last;
		end
	end

	mns_core #(
		.SONG_SLOTS    (SONG_SLOTS),
		.NOTES_PER_SONG(NOTES_PER_SONG)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.song_count(song_count_r_q),
		.issue     (issue),
		.item      (buf_item_q),
		.busy      (busy),
		.res_valid (core_valid),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_valid) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_valid) begin
			res_q <= core_res;
		end
	end

	assign res_valid  = out_valid_q;
	assign tone_hz    = res_q.tone_hz;
	assign mode       = res_q.mode;
	assign song_sel   = res_q.song_sel;
	assign note_pos   = res_q.note_pos;
	assign song_done  = res_q.song_done;
	assign cmd_status = res_q.cmd_status;

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		core_valid |-> !out_valid_q)
		else $error("result produced while output register still occupied");

	a_cfg_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> song_count_q && song_count_r_q == $past(cfg_data))
		else $error("song_count write lost");

endmodule
